// ----- hw/rtl/cfc_pkg.sv -----
package cfc_pkg;

  // Keys are full 32-bit words; the count width is a top-level parameter.
  localparam int unsigned KEY_W = 32;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_e;

  // Per-cell update strobes, decided centrally and handed to every cell.
  typedef struct packed {
    logic load;   // take the broadcast key with a count of one
    logic incr;   // saturating increment of the held count
    logic decr;   // decrement of the held count
    logic shift;  // take the contents of the neighbour behind
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/cfc_cell.sv -----
module cfc_cell #(
  parameter int unsigned CountBits = 16
) (
  input  logic                        clk_i,
  input  cfc_pkg::cell_ctrl_t         ctrl_i,
  input  logic                        valid_i,
  input  logic [cfc_pkg::KEY_W-1:0]   bcast_key_i,
  input  logic [cfc_pkg::KEY_W-1:0]   next_key_i,
  input  logic [CountBits-1:0]        next_count_i,
  output logic                        hit_o,
  output logic [cfc_pkg::KEY_W-1:0]   key_o,
  output logic [CountBits-1:0]        count_o
);
  import cfc_pkg::*;

  logic [KEY_W-1:0]     key_q, key_d;
  logic [CountBits-1:0] count_q, count_d;

  // The cell only claims a match while it lies inside the occupied region.
  assign hit_o   = valid_i && (key_q == bcast_key_i);
  assign key_o   = key_q;
  assign count_o = count_q;

  always_comb begin
    key_d   = key_q;
    count_d = count_q;
    if (ctrl_i.shift) begin
      key_d   = next_key_i;
      count_d = next_count_i;
    end else if (ctrl_i.load) begin
      key_d   = bcast_key_i;
      count_d = CountBits'(1);
    end else if (ctrl_i.incr) begin
      if (count_q != {CountBits{1'b1}}) begin
        count_d = count_q + CountBits'(1);
      end
    end else if (ctrl_i.decr) begin
      count_d = count_q - CountBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    count_q <= count_d;
  end

endmodule

// ----- hw/rtl/coalescing_count_fifo.sv -----
// A pop, or a push that is dropped, shows its result in the cycle after its input beat.
// Throughput: one beat per cycle while in_stall_o is low; a push that merges or appends
// produces no result beat; the rate rests on the combinational broadcast compare in each cell.
// Reset clears the occupancy and the result valid flag; cell contents are left undefined.
module coalescing_count_fifo #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cfc_pkg::opcode_e   opcode_i,
  input  logic signed [31:0] key_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] front_key_o,
  output logic               queue_empty_o,
  output logic               push_dropped_o
);
  import cfc_pkg::*;

  localparam int unsigned OCC_W = $clog2(DEPTH + 1);

  // Occupancy counter: cells below it are valid, the front lives in cell 0.
  logic [OCC_W-1:0] occ_q, occ_d;

  logic [DEPTH-1:0]      hit;
  logic [DEPTH-1:0]      cell_valid;
  cell_ctrl_t            ctrl [DEPTH];
  logic [KEY_W-1:0]      cell_key [DEPTH];
  logic [COUNT_BITS-1:0] cell_count [DEPTH];
  logic [KEY_W-1:0]      bcast_key;

  logic accept, is_push, is_pop, any_hit, full, empty;
  logic do_load, do_shift, do_decr;

  logic        out_valid_q, out_valid_d;
  logic [31:0] front_key_q, front_key_d;
  logic        queue_empty_q, queue_empty_d;
  logic        push_dropped_q, push_dropped_d;

  // The result register stands between the two sides: a new beat is taken
  // whenever the register is free or is being emptied in this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_push    = accept && (opcode_i == OP_PUSH);
  assign is_pop     = accept && (opcode_i == OP_POP);
  assign bcast_key  = key_i;

  assign any_hit = |hit;
  assign full    = (occ_q == OCC_W'(DEPTH));
  assign empty   = (occ_q == '0);

  // A new key is appended at the first free cell, unless the row is full.
  assign do_load = is_push && !any_hit && !full;
  // A pop removes the front entry only when its count would reach zero.
  assign do_shift = is_pop && !empty && (cell_count[0] <= COUNT_BITS'(1));
  assign do_decr  = is_pop && !empty && (cell_count[0] >  COUNT_BITS'(1));

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [KEY_W-1:0]      nb_key;
    logic [COUNT_BITS-1:0] nb_count;

    if (gi == DEPTH - 1) begin : g_tail
      assign nb_key   = '0;
      assign nb_count = '0;
    end else begin : g_body
      assign nb_key   = cell_key[gi+1];
      assign nb_count = cell_count[gi+1];
    end

    assign cell_valid[gi] = (OCC_W'(gi) < occ_q);

    always_comb begin
      ctrl[gi].load  = do_load && (OCC_W'(gi) == occ_q);
      ctrl[gi].incr  = is_push && hit[gi];
      ctrl[gi].decr  = do_decr && (gi == 0);
      ctrl[gi].shift = do_shift;
    end

    cfc_cell #(
      .CountBits (COUNT_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl[gi]),
      .valid_i      (cell_valid[gi]),
      .bcast_key_i  (bcast_key),
      .next_key_i   (nb_key),
      .next_count_i (nb_count),
      .hit_o        (hit[gi]),
      .key_o        (cell_key[gi]),
      .count_o      (cell_count[gi])
    );
  end

  always_comb begin
    occ_d = occ_q;
    if (do_load) begin
      occ_d = occ_q + OCC_W'(1);
    end else if (do_shift) begin
      occ_d = occ_q - OCC_W'(1);
    end
  end

  // Every pop yields a result beat; a push yields one only when it is dropped.
  always_comb begin
    out_valid_d    = out_valid_q && out_stall_i;
    front_key_d    = front_key_q;
    queue_empty_d  = queue_empty_q;
    push_dropped_d = push_dropped_q;
    if (is_pop) begin
      out_valid_d    = 1'b1;
      front_key_d    = empty ? 32'd0 : cell_key[0];
      queue_empty_d  = empty;
      push_dropped_d = 1'b0;
    end else if (is_push && !any_hit && full) begin
      out_valid_d    = 1'b1;
      front_key_d    = 32'd0;
      queue_empty_d  = 1'b0;
      push_dropped_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_key_q    <= front_key_d;
    queue_empty_q  <= queue_empty_d;
    push_dropped_q <= push_dropped_d;
  end

  assign out_valid_o    = out_valid_q;
  assign front_key_o    = front_key_q;
  assign queue_empty_o  = queue_empty_q;
  assign push_dropped_o = push_dropped_q;

  // The occupancy never runs past the number of cells.
  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(DEPTH))
    else $error("occupancy exceeds depth");

  // Queued keys are distinct, so at most one cell can match.
  a_hit_unique : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit))
    else $error("several cells match the pushed key");

  // A new key into a full row is reported as dropped and leaves the row alone.
  a_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_push && !any_hit && full) |=> (out_valid_o && push_dropped_o && occ_q == $past(occ_q)))
    else $error("dropped push not reported");

  // A pop on an empty queue reports empty and changes nothing.
  a_empty_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_pop && empty) |=> (out_valid_o && queue_empty_o && occ_q == '0))
    else $error("empty pop not reported");

endmodule

// ----- dv/tb_coalescing_count_fifo.sv -----
module tb_coalescing_count_fifo;
  timeunit 1ns;
  timeprecision 1ps;

  import cfc_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned IDLE_LIMIT = 5000;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // One input beat as the stimulus generator plans it.
  typedef struct {
    opcode_e            op;
    logic signed [31:0] key;
    int unsigned        idle;    // cycles of idling before the beat is offered
    bit                 settle;  // hold back until every owed result has come
  } queue_op_t;

  // One result beat as the block should deliver it.
  typedef struct packed {
    logic signed [31:0] front_key;
    logic               queue_empty;
    logic               push_dropped;
  } queue_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  opcode_e            opcode      = OP_PUSH;
  logic signed [31:0] key         = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic signed [31:0] front_key;
  logic               queue_empty;
  logic               push_dropped;

  coalescing_count_fifo #(
    .DEPTH      (DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .opcode_i       (opcode),
    .key_i          (key),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .front_key_o    (front_key),
    .queue_empty_o  (queue_empty),
    .push_dropped_o (push_dropped)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Shadow copy of the key table. Cell 0 is the front of the queue, and only
  // cells below shadow_used are ever looked at.
  logic signed [31:0]    shadow_key [DEPTH];
  logic [COUNT_BITS-1:0] shadow_cnt [DEPTH];
  int unsigned           shadow_used = 0;

  queue_op_t     pending_ops[$];
  queue_result_t owed_results[$];

  int unsigned n_mismatch    = 0;
  int unsigned n_in_beats    = 0;
  int unsigned n_out_beats   = 0;
  int unsigned n_merged      = 0;
  int unsigned n_saturated   = 0;
  int unsigned n_dropped     = 0;
  int unsigned n_empty_pops  = 0;
  int unsigned n_fronts      = 0;
  int unsigned peak_used     = 0;

  int unsigned tx_idle       = 0;
  int unsigned rx_stall_left = 0;
  int unsigned rx_mode_left  = 0;
  bit          rx_calm       = 1'b0;
  int unsigned quiet_cycles  = 0;

  task automatic note_mismatch(input string what);
    n_mismatch++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Idle lengths for both sides: mostly none, otherwise a pause, now and then
  // a long one, so that gaps land on every phase of the block's work.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Apply one accepted beat to the shadow table and queue the result beat it
  // owes, if any. A push merges into a queued key, appends a new key, or is
  // dropped when the table is full; a pop on an empty table reports empty,
  // else the front and lowers its count; the entry leaves only at zero.
  function automatic void predict_queue_op(input opcode_e op, input logic signed [31:0] k);
    queue_result_t res;
    int            hit;
    hit = -1;
    res = '{front_key: '0, queue_empty: 1'b0, push_dropped: 1'b0};
    if (op == OP_PUSH) begin
      for (int i = 0; i < int'(shadow_used); i++) begin
        if (hit < 0 && shadow_key[i] == k) hit = i;
      end
      if (hit >= 0) begin
        n_merged++;
        if (shadow_cnt[hit] != COUNT_MAX) shadow_cnt[hit]++;
        else n_saturated++;
      end else if (shadow_used == DEPTH) begin
        res.push_dropped = 1'b1;
        owed_results.push_back(res);
        n_dropped++;
      end else begin
        shadow_key[shadow_used] = k;
        shadow_cnt[shadow_used] = COUNT_BITS'(1);
        shadow_used++;
        if (shadow_used > peak_used) peak_used = shadow_used;
      end
    end else if (shadow_used == 0) begin
      res.queue_empty = 1'b1;
      owed_results.push_back(res);
      n_empty_pops++;
    end else begin
      res.front_key = shadow_key[0];
      owed_results.push_back(res);
      n_fronts++;
      if (shadow_cnt[0] > 1) begin
        shadow_cnt[0]--;
      end else begin
        for (int i = 1; i < int'(shadow_used); i++) begin
          shadow_key[i-1] = shadow_key[i];
          shadow_cnt[i-1] = shadow_cnt[i];
        end
        shadow_used--;
      end
    end
  endfunction

  function automatic void plan_op(input opcode_e op, input logic signed [31:0] k,
                                  input int unsigned idle, input bit settle);
    queue_op_t item;
    item.op     = op;
    item.key    = k;
    item.idle   = idle;
    item.settle = settle;
    pending_ops.push_back(item);
  endfunction

  // Input side. The beat on the port is predicted at the edge where it is
  // taken; the next planned beat then goes up once its idle time has passed
  // and, where it asks for it, once every owed result has been collected.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      opcode   <= OP_PUSH;
      key      <= '0;
      tx_idle   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_queue_op(opcode, key);
        n_in_beats++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() != 0 && tx_idle >= pending_ops[0].idle &&
            !(pending_ops[0].settle && owed_results.size() != 0)) begin
          opcode   <= pending_ops[0].op;
          key      <= pending_ops[0].key;
          in_valid <= 1'b1;
          void'(pending_ops.pop_front());
          tx_idle   = 0;
        end else begin
          in_valid <= 1'b0;
          tx_idle++;
        end
      end
    end
  end

  // Output side. Every taken result beat is held against the oldest owed
  // result, field by field. The stall pattern switches between calm stretches
  // and stretches of random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall    <= 1'b0;
      rx_stall_left = 0;
      rx_mode_left  = 0;
      rx_calm       = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_out_beats++;
        if (owed_results.size() == 0) begin
          note_mismatch($sformatf("result beat with nothing owed (front_key %0d)", front_key));
        end else begin
          if (front_key !== owed_results[0].front_key)
            note_mismatch($sformatf("front_key %0d, wanted %0d",
                                    front_key, owed_results[0].front_key));
          if (queue_empty !== owed_results[0].queue_empty)
            note_mismatch($sformatf("queue_empty %b, wanted %b",
                                    queue_empty, owed_results[0].queue_empty));
          if (push_dropped !== owed_results[0].push_dropped)
            note_mismatch($sformatf("push_dropped %b, wanted %b",
                                    push_dropped, owed_results[0].push_dropped));
          void'(owed_results.pop_front());
        end
      end
      if (rx_mode_left == 0) begin
        rx_mode_left = $urandom_range(100, 800);
        rx_calm      = ($urandom_range(0, 3) == 0);
      end else begin
        rx_mode_left--;
      end
      if (rx_stall_left != 0) begin
        rx_stall_left--;
        out_stall <= 1'b1;
      end else if (!rx_calm && $urandom_range(0, 4) == 0) begin
        rx_stall_left = pick_gap();
        out_stall    <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: a long spell with no beat taken on either side means a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results still owed",
                 quiet_cycles, owed_results.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic signed [31:0] key_pool [28];
    logic signed [31:0] pick;
    int unsigned        push_pct;
    bit                 gappy;

    // Directed opening: a pop on the empty queue, the extreme keys, a merge,
    // then the table filled to the brim so that a new key is dropped while a
    // repeat of a queued key still merges.
    plan_op(OP_POP, '0, pick_gap(), 1'b0);
    plan_op(OP_PUSH, 32'sh7FFF_FFFF, pick_gap(), 1'b0);
    plan_op(OP_PUSH, 32'sh8000_0000, pick_gap(), 1'b0);
    plan_op(OP_PUSH, 32'sh0000_0000, pick_gap(), 1'b0);
    plan_op(OP_PUSH, 32'shFFFF_FFFF, pick_gap(), 1'b0);
    plan_op(OP_PUSH, 32'sh8000_0000, pick_gap(), 1'b0);
    plan_op(OP_PUSH, 32'sh5555_5555, pick_gap(), 1'b0);
    plan_op(OP_PUSH, 32'shAAAA_AAAA, pick_gap(), 1'b0);
    for (int i = 1; i <= 10; i++) plan_op(OP_PUSH, 32'sd1 <<< i, pick_gap(), 1'b0);
    plan_op(OP_PUSH, 32'sh1234_5678, pick_gap(), 1'b0);
    plan_op(OP_PUSH, 32'sh0000_0000, pick_gap(), 1'b0);
    for (int i = 0; i < 4; i++) plan_op(OP_POP, $urandom, pick_gap(), 1'b0);

    // Repeats: first run the queue dry (the surplus pops land on the empty
    // queue), then push one key over and over and pop it all the way out
    // again. The exact number of fronts reported shows that every repeat was
    // counted. The stretch after the drain runs without input gaps.
    for (int i = 0; i < 24; i++) plan_op(OP_POP, $urandom, pick_gap(), 1'b0);
    plan_op(OP_PUSH, 32'sh5A5A_C3C3, 0, 1'b1);
    for (int i = 0; i < 20; i++) plan_op(OP_PUSH, 32'sh5A5A_C3C3, 0, 1'b0);
    plan_op(OP_PUSH, 32'sh0F0F_0F0F, 0, 1'b0);
    for (int i = 0; i < 24; i++) plan_op(OP_POP, $urandom, 0, 1'b0);

    // Random part: keys mostly from a pool larger than the table, so that
    // merges, fills and drops all occur, with the push share varying from
    // phase to phase to swing the occupancy between empty and full.
    key_pool[0] = 32'sh7FFF_FFFF;
    key_pool[1] = 32'sh8000_0000;
    key_pool[2] = 32'sh0000_0000;
    key_pool[3] = 32'shFFFF_FFFF;
    for (int i = 4; i < 28; i++) key_pool[i] = $urandom;
    for (int phase = 0; phase < 15; phase++) begin
      case ($urandom_range(0, 3))
        0: push_pct = 25;
        1: push_pct = 50;
        2: push_pct = 70;
        default: push_pct = 90;
      endcase
      gappy = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 99) < 85) pick = key_pool[$urandom_range(0, 27)];
        else pick = $urandom;
        plan_op(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP, pick,
                gappy ? pick_gap() : 0, (phase == 7 && i == 0));
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || in_valid) @(posedge clk_i);
    while (owed_results.size() != 0) @(posedge clk_i);
    // A wait at the end catches any stray result beat that should not be there.
    repeat (8) @(posedge clk_i);

    $display("summary: %0d input beats, %0d result beats, %0d fronts, %0d empty pops",
             n_in_beats, n_out_beats, n_fronts, n_empty_pops);
    $display("summary: %0d merges (%0d at the count ceiling), %0d drops, peak occupancy %0d",
             n_merged, n_saturated, n_dropped, peak_used);
    if (n_mismatch == 0 && owed_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/cfc_pkg.sv
hw/rtl/cfc_cell.sv
hw/rtl/coalescing_count_fifo.sv
dv/tb_coalescing_count_fifo.sv
